### design/osbr_pkg.sv
// Shared types and constants of the oversampled serial byte receiver.
package osbr_pkg;

    localparam int DATA_BITS  = 8;
    localparam int TICK_W     = 10;
    localparam int CNT_W      = 5;
    localparam int WIN_W      = 11;
    localparam int BYTE_W     = 8;
    localparam int FS_W       = 8;
    localparam int SPB_W      = 5;
    localparam int THR_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CNT_W-1:0]  CNT_MAX         = 5'd31;
    localparam logic [FS_W-1:0]   FIRST_SAMPLE_RST = 8'd12;
    localparam logic [SPB_W-1:0]  SPB_RST          = 5'd10;
    localparam logic [THR_W-1:0]  THR_RST          = 5'd4;
    localparam logic [TICK_W-1:0] FRAME_TICKS_RST  = 10'd117;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_SAMPLE    = 2'd0,
        CFG_SAMPLES_PER_BIT = 2'd1,
        CFG_VOTE_THRESHOLD  = 2'd2,
        CFG_FRAME_TICKS     = 2'd3
    } t_cfg_idx;

    // Per-sample control handed from the frame sequencer to every bit lane.
    typedef struct packed {
        logic              step;
        logic              done;
        logic              level;
        logic [TICK_W-1:0] tick;
    } t_lane_ctl;

endpackage

### design/osbr_if.sv
// Channel interfaces: line samples in, received bytes out, register writes.
interface osbr_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink (input valid, input line_level, output ready);
endinterface

interface osbr_out_if;
    logic                       valid;
    logic                       ready;
    logic [osbr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface osbr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [osbr_pkg::CFG_IDX_W-1:0]  index;
    logic [osbr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### design/osbr_in_stage.sv
// Input register for line samples.
module osbr_in_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    osbr_in_if.sink      i_in,
    input  logic         i_take,
    output logic         o_valid,
    output logic         o_level
);

    logic r_valid;
    logic n_valid;
    logic r_level;
    logic w_accept;

    assign i_in.ready = !r_valid || i_take;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_level <= i_in.line_level;
        end
    end

    assign o_valid = r_valid;
    assign o_level = r_level;

endmodule

### design/osbr_vote_lane.sv
// One data bit: window match, saturating high-sample count and vote.
module osbr_vote_lane #(
    parameter int BIT_IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  osbr_pkg::t_lane_ctl           i_ctl,
    input  logic [osbr_pkg::FS_W-1:0]     i_first_sample,
    input  logic [osbr_pkg::SPB_W-1:0]    i_samples_per_bit,
    input  logic [osbr_pkg::THR_W-1:0]    i_vote_threshold,
    output logic                          o_vote
);

    logic [osbr_pkg::WIN_W-1:0] w_start;
    logic [osbr_pkg::WIN_W-1:0] w_stop;
    logic [osbr_pkg::WIN_W-1:0] w_tick;
    logic                       w_hit;
    logic [osbr_pkg::CNT_W-1:0] w_counted;
    logic [osbr_pkg::CNT_W-1:0] r_cnt;
    logic [osbr_pkg::CNT_W-1:0] n_cnt;

    // Multiplication by the lane's own constant index.
    assign w_start = osbr_pkg::WIN_W'(i_first_sample)
                   + osbr_pkg::WIN_W'(BIT_IDX) * osbr_pkg::WIN_W'(i_samples_per_bit);
    assign w_stop  = w_start + osbr_pkg::WIN_W'(i_samples_per_bit);
    assign w_tick  = osbr_pkg::WIN_W'(i_ctl.tick);
    assign w_hit   = (w_tick >= w_start) && (w_tick < w_stop);

    assign w_counted = (i_ctl.level && w_hit && (r_cnt != osbr_pkg::CNT_MAX))
                     ? r_cnt + osbr_pkg::CNT_W'(1) : r_cnt;

    // The vote includes the sample of this beat, which matters on the last tick.
    assign o_vote = w_counted > i_vote_threshold;

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.step) begin
            n_cnt = i_ctl.done ? '0 : w_counted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

### design/osbr_out_reg.sv
// Output register that holds a received byte until the sink takes it.
module osbr_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [osbr_pkg::BYTE_W-1:0] i_byte,
    osbr_out_if.source                  o_out,
    output logic                        o_can_load
);

    logic                        r_valid;
    logic                        n_valid;
    logic [osbr_pkg::BYTE_W-1:0] r_byte;

    assign o_can_load = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_byte;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.rx_byte = r_byte;

endmodule

### design/oversampled_serial_byte_receiver.sv
// An accepted sample is held in the input register and processed when it advances; a frame's
// byte is loaded into the output register as its last sample advances and is shown on o_out.
// Throughput: one line sample per cycle, set by the single registered pass through
// the bit lanes; while a byte waits, samples still go in but a frame's last one stalls.
// Reset (synchronous, active low) returns to idle, clears counts and restores defaults.
module oversampled_serial_byte_receiver #(
    parameter int DATA_BITS = osbr_pkg::DATA_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    osbr_in_if.sink     i_in,
    osbr_out_if.source  o_out,
    osbr_cfg_if.sink    i_cfg
);

    logic [osbr_pkg::FS_W-1:0]   r_first_sample;
    logic [osbr_pkg::SPB_W-1:0]  r_samples_per_bit;
    logic [osbr_pkg::THR_W-1:0]  r_vote_threshold;
    logic [osbr_pkg::TICK_W-1:0] r_frame_ticks;

    logic                        r_busy;
    logic                        n_busy;
    logic [osbr_pkg::TICK_W-1:0] r_tick;
    logic [osbr_pkg::TICK_W-1:0] n_tick;

    logic                        w_in_valid;
    logic                        w_level;
    logic                        w_active;
    logic [osbr_pkg::TICK_W-1:0] w_last;
    logic                        w_done;
    logic                        w_can_load;
    logic                        w_advance;
    osbr_pkg::t_lane_ctl         w_ctl;
    logic [DATA_BITS-1:0]        w_vote;
    logic [osbr_pkg::BYTE_W-1:0] w_byte;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sample    <= osbr_pkg::FIRST_SAMPLE_RST;
            r_samples_per_bit <= osbr_pkg::SPB_RST;
            r_vote_threshold  <= osbr_pkg::THR_RST;
            r_frame_ticks     <= osbr_pkg::FRAME_TICKS_RST;
        end else if (i_cfg.valid) begin
            case (osbr_pkg::t_cfg_idx'(i_cfg.index))
                osbr_pkg::CFG_FIRST_SAMPLE: begin
                    r_first_sample <= osbr_pkg::FS_W'(i_cfg.data);
                end
                osbr_pkg::CFG_SAMPLES_PER_BIT: begin
                    r_samples_per_bit <= osbr_pkg::SPB_W'(i_cfg.data);
                end
                osbr_pkg::CFG_VOTE_THRESHOLD: begin
                    r_vote_threshold <= osbr_pkg::THR_W'(i_cfg.data);
                end
                osbr_pkg::CFG_FRAME_TICKS: begin
                    r_frame_ticks <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    osbr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_advance),
        .o_valid (w_in_valid),
        .o_level (w_level)
    );

    // A high sample while idle belongs to no frame and is dropped.
    assign w_active  = r_busy || !w_level;
    assign w_last    = r_frame_ticks - osbr_pkg::TICK_W'(1);
    assign w_done    = w_active && (r_tick == w_last);
    assign w_advance = w_in_valid && (!w_done || w_can_load);

    // Tick and counts are zero while idle, so a start sample needs no clearing.
    assign w_ctl.step  = w_advance && w_active;
    assign w_ctl.done  = w_done;
    assign w_ctl.level = w_level && r_busy;
    assign w_ctl.tick  = r_tick;

    always_comb begin
        n_busy = r_busy;
        n_tick = r_tick;
        if (w_ctl.step) begin
            if (w_done) begin
                n_busy = 1'b0;
                n_tick = '0;
            end else begin
                n_busy = 1'b1;
                n_tick = r_tick + osbr_pkg::TICK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tick <= '0;
        end else begin
            r_busy <= n_busy;
            r_tick <= n_tick;
        end
    end

    for (genvar k = 0; k < DATA_BITS; k++) begin : g_lane
        osbr_vote_lane #(
            .BIT_IDX (k)
        ) u_lane (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_ctl             (w_ctl),
            .i_first_sample    (r_first_sample),
            .i_samples_per_bit (r_samples_per_bit),
            .i_vote_threshold  (r_vote_threshold),
            .o_vote            (w_vote[k])
        );
    end

    // Bits beyond the byte are counted but not delivered.
    for (genvar b = 0; b < osbr_pkg::BYTE_W; b++) begin : g_byte
        if (b < DATA_BITS) begin : g_used
            assign w_byte[b] = w_vote[b];
        end else begin : g_zero
            assign w_byte[b] = 1'b0;
        end
    end

    osbr_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_done),
        .i_byte     (w_byte),
        .o_out      (o_out),
        .o_can_load (w_can_load)
    );

`ifndef SYNTHESIS
    a_idle_tick_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_tick == '0))
        else $error("tick index nonzero while idle");

    a_done_loads_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_done) |=> (o_out.valid && !r_busy))
        else $error("frame end did not present a byte");

    a_held_sample : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_advance) |=> (w_in_valid && $stable(w_level)))
        else $error("stalled sample lost");

    a_stall_only_on_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_advance) |-> (w_done && o_out.valid))
        else $error("sample stalled without a waiting byte");
`endif

endmodule

### tb/oversampled_serial_byte_receiver_test.sv
// Self-checking testbench for the oversampled serial byte receiver.
`timescale 1ns / 100ps

module oversampled_serial_byte_receiver_test;

    localparam int IDLE_PCT      = 26;
    localparam int HOLD_CYCLES   = 300;
    localparam int STUCK_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 250;
    localparam int RANDOM_FRAMES = 25;
    localparam int SETTLE_CYCLES = 4;

    logic i_clk;
    logic i_rst_n;

    osbr_in_if  line_ch ();
    osbr_out_if byte_ch ();
    osbr_cfg_if reg_ch ();

    oversampled_serial_byte_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (line_ch),
        .o_out   (byte_ch),
        .i_cfg   (reg_ch)
    );

    // Line samples waiting to be offered, and the bytes the receiver should produce.
    logic                        line_samples [$];
    logic [osbr_pkg::BYTE_W-1:0] expected_bytes [$];

    // Shadow copy of the receiver's registers and frame state.
    logic [osbr_pkg::FS_W-1:0]   cfg_first;
    logic [osbr_pkg::SPB_W-1:0]  cfg_spb;
    logic [osbr_pkg::THR_W-1:0]  cfg_thr;
    logic [osbr_pkg::TICK_W-1:0] cfg_frame;
    bit                          frame_busy;
    logic [osbr_pkg::TICK_W-1:0] frame_tick;
    logic [osbr_pkg::CNT_W-1:0]  bit_votes [osbr_pkg::DATA_BITS];

    logic                        line_taken;
    logic [osbr_pkg::BYTE_W-1:0] want_byte;
    int                          mismatches;
    int                          stuck_cycles;
    int                          stim_items;
    int                          frames_sent;
    bit                          no_idle;
    bit                          stall_req;
    bit                          stall_started;
    int                          hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Follows one accepted line sample through the frame and queues the byte at frame end.
    task automatic track_line_sample(input logic level);
        int                          win_lo;
        logic [osbr_pkg::BYTE_W-1:0] rx;
        logic [osbr_pkg::TICK_W-1:0] last_tick;
        last_tick = cfg_frame - 1'b1;
        if (!frame_busy) begin
            if (level) return;
            frame_busy = 1'b1;
            frame_tick = '0;
            foreach (bit_votes[k]) bit_votes[k] = '0;
        end
        if (level) begin
            for (int k = 0; k < osbr_pkg::DATA_BITS; k++) begin
                win_lo = int'(cfg_first) + k * int'(cfg_spb);
                if (int'(frame_tick) >= win_lo && int'(frame_tick) < win_lo + int'(cfg_spb) &&
                    bit_votes[k] != osbr_pkg::CNT_MAX) begin
                    bit_votes[k] = bit_votes[k] + 1'b1;
                end
            end
        end
        if (frame_tick != last_tick) begin
            frame_tick = frame_tick + 1'b1;
            return;
        end
        rx = '0;
        for (int k = 0; k < osbr_pkg::DATA_BITS; k++) begin
            if (k < osbr_pkg::BYTE_W && bit_votes[k] > cfg_thr) rx[k] = 1'b1;
        end
        expected_bytes.push_back(rx);
        frame_busy = 1'b0;
        frame_tick = '0;
    endtask

    // Writes all four registers back to back; bits above each field are random.
    task automatic write_config(input int first, input int spb, input int thr, input int frame);
        osbr_pkg::t_cfg_idx              idx;
        int                              value;
        int                              width;
        logic [osbr_pkg::CFG_DATA_W-1:0] field_mask;
        idx = osbr_pkg::CFG_FIRST_SAMPLE;
        repeat (idx.num()) begin
            case (idx)
                osbr_pkg::CFG_FIRST_SAMPLE: begin
                    value = first; width = osbr_pkg::FS_W;
                end
                osbr_pkg::CFG_SAMPLES_PER_BIT: begin
                    value = spb; width = osbr_pkg::SPB_W;
                end
                osbr_pkg::CFG_VOTE_THRESHOLD: begin
                    value = thr; width = osbr_pkg::THR_W;
                end
                default: begin
                    value = frame; width = osbr_pkg::TICK_W;
                end
            endcase
            field_mask = (osbr_pkg::CFG_DATA_W'(1) << width) - 1'b1;
            if (width >= osbr_pkg::CFG_DATA_W) field_mask = '1;
            @(negedge i_clk);
            reg_ch.valid <= 1'b1;
            reg_ch.index <= idx;
            reg_ch.data  <= (osbr_pkg::CFG_DATA_W'(value) & field_mask) |
                            (osbr_pkg::CFG_DATA_W'($urandom) & ~field_mask);
            do @(posedge i_clk); while (!reg_ch.ready);
            idx = idx.next();
        end
        @(negedge i_clk);
        reg_ch.valid <= 1'b0;
    endtask

    // Queues one frame: idle high samples, a start sample, then each data window driven to its bit,
    // with a given chance of flipping any sample after the start.
    task automatic queue_frame(input logic [osbr_pkg::BYTE_W-1:0] data, input int flip_pct);
        int   len;
        int   win;
        logic lvl;
        len = (cfg_frame == 0) ? (1 << osbr_pkg::TICK_W) : int'(cfg_frame);
        repeat ($urandom_range(0, 2)) line_samples.push_back(1'b1);
        line_samples.push_back(1'b0);
        for (int t = 1; t < len; t++) begin
            if (cfg_spb == 0 || t < int'(cfg_first)) win = -1;
            else win = (t - int'(cfg_first)) / int'(cfg_spb);
            if (win >= 0 && win < osbr_pkg::BYTE_W) lvl = data[win];
            else lvl = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < flip_pct) lvl = ~lvl;
            line_samples.push_back(lvl);
        end
        stim_items += len;
        frames_sent++;
    endtask

    // Holds the sender until every queued sample is taken and every byte has come back.
    task automatic wait_drained();
        while (line_samples.size() != 0 || line_ch.valid || expected_bytes.size() != 0 ||
               frame_busy) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sample driver.
    always @(negedge i_clk) begin
        if (i_rst_n && !(line_ch.valid && !line_taken)) begin
            if (line_samples.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                line_ch.valid      <= 1'b1;
                line_ch.line_level <= line_samples.pop_front();
            end else begin
                line_ch.valid <= 1'b0;
            end
        end
    end

    // Byte receiver side: random stalls plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (stall_req && !stall_started) begin
            stall_started = 1'b1;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            byte_ch.ready <= 1'b0;
        end else begin
            byte_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Beat tracking, prediction, checking and the watchdog.
    always @(posedge i_clk) begin
        line_taken = line_ch.valid && line_ch.ready;
        if (!i_rst_n) begin
            cfg_first    = osbr_pkg::FIRST_SAMPLE_RST;
            cfg_spb      = osbr_pkg::SPB_RST;
            cfg_thr      = osbr_pkg::THR_RST;
            cfg_frame    = osbr_pkg::FRAME_TICKS_RST;
            frame_busy   = 1'b0;
            frame_tick   = '0;
            stuck_cycles = 0;
        end else begin
            if (reg_ch.valid && reg_ch.ready) begin
                case (osbr_pkg::t_cfg_idx'(reg_ch.index))
                    osbr_pkg::CFG_FIRST_SAMPLE:
                        cfg_first = reg_ch.data[osbr_pkg::FS_W-1:0];
                    osbr_pkg::CFG_SAMPLES_PER_BIT:
                        cfg_spb   = reg_ch.data[osbr_pkg::SPB_W-1:0];
                    osbr_pkg::CFG_VOTE_THRESHOLD:
                        cfg_thr   = reg_ch.data[osbr_pkg::THR_W-1:0];
                    osbr_pkg::CFG_FRAME_TICKS:
                        cfg_frame = reg_ch.data[osbr_pkg::TICK_W-1:0];
                    default: ;
                endcase
            end
            if (line_taken) track_line_sample(line_ch.line_level);
            if (byte_ch.valid && byte_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("rx_byte: expected none, actual %02h", byte_ch.rx_byte);
                    mismatches++;
                end else begin
                    want_byte = expected_bytes.pop_front();
                    if (byte_ch.rx_byte !== want_byte) begin
                        $error("rx_byte: expected %02h, actual %02h", want_byte, byte_ch.rx_byte);
                        mismatches++;
                    end
                end
            end
            if (line_taken || (byte_ch.valid && byte_ch.ready) || (reg_ch.valid && reg_ch.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("oversampled_serial_byte_receiver_test: FAIL");
            $finish;
        end
    end

    initial begin
        int first;
        int spb;
        int thr;
        int frame;
        int nframes;
        int phase;

        i_rst_n            = 1'b0;
        line_ch.valid      = 1'b0;
        line_ch.line_level = 1'b1;
        byte_ch.ready      = 1'b0;
        reg_ch.valid       = 1'b0;
        reg_ch.index       = osbr_pkg::CFG_FIRST_SAMPLE;
        reg_ch.data        = '0;
        mismatches         = 0;
        stim_items         = 0;
        frames_sent        = 0;
        hold_left          = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A frame at the reset register values.
        queue_frame(8'hA5, 4);
        wait_drained();

        // Single-tick frames, with high samples in between that must be ignored.
        write_config(0, 1, 0, 1);
        line_samples = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
        wait_drained();

        // One-tick windows; the upper bits' windows fall past the end of the frame.
        write_config(0, 1, 0, 4);
        line_samples = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
        wait_drained();

        // Empty windows leave every bit at zero.
        write_config(2, 0, 0, 3);
        line_samples = '{1'b0, 1'b1, 1'b1};
        wait_drained();

        // Random phases with short frames so that bytes come often.
        stim_items  = 0;
        frames_sent = 0;
        phase       = 0;
        while (stim_items < RANDOM_ITEMS || frames_sent < RANDOM_FRAMES) begin
            first = $urandom_range(0, 6);
            spb   = $urandom_range(1, 4);
            thr   = $urandom_range(0, spb);
            frame = first + osbr_pkg::BYTE_W * spb + $urandom_range(0, 3);
            if ($urandom_range(0, 4) == 0) frame = $urandom_range(1, frame);
            write_config(first, spb, thr, frame);
            nframes = $urandom_range(3, 6);
            // Keep feeding while the output side holds off, so the block backs up.
            if (phase == 2) begin
                stall_req = 1'b1;
                nframes   = 8;
            end
            repeat (nframes) begin
                if ($urandom_range(0, 4) == 0) begin
                    queue_frame(osbr_pkg::BYTE_W'($urandom), 50);
                end else begin
                    queue_frame(osbr_pkg::BYTE_W'($urandom), $urandom_range(0, 8));
                end
            end
            wait_drained();
            phase++;
        end

        // Register extremes, run with no idling; only part of the second window fits.
        no_idle = 1'b1;
        write_config(255, 31, 30, 290);
        queue_frame(osbr_pkg::BYTE_W'($urandom), 3);
        wait_drained();
        no_idle = 1'b0;

        // The highest threshold can never be exceeded.
        write_config(0, 31, 31, 100);
        queue_frame(8'hFF, 0);
        wait_drained();

        write_config(5, 0, 0, 20);
        queue_frame(osbr_pkg::BYTE_W'($urandom), 20);
        queue_frame(8'hFF, 0);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("oversampled_serial_byte_receiver_test: PASS");
        end else begin
            $display("oversampled_serial_byte_receiver_test: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
design/osbr_pkg.sv
design/osbr_if.sv
design/osbr_in_stage.sv
design/osbr_vote_lane.sv
design/osbr_out_reg.sv
design/oversampled_serial_byte_receiver.sv
tb/oversampled_serial_byte_receiver_test.sv
